>>> rtl/core/brts_pkg.sv
// Shared types and constants for the bilinear RGBA texture sampler.
`timescale 1ns / 1ps
package brts_pkg;

  typedef enum logic {
    OP_WRITE  = 1'b0,
    OP_SAMPLE = 1'b1
  } op_e;

  typedef enum logic {
    REG_WIDTH  = 1'b0,
    REG_HEIGHT = 1'b1
  } reg_idx_e;

  localparam int CFG_W        = 9;
  localparam int COORD_W      = 18;
  localparam int IDX_W        = 8;
  localparam int TEXEL_W      = 32;
  localparam int CHAN_W       = 8;
  localparam int IN_TDATA_W   = 88;
  localparam int OUT_TDATA_W  = 32;
  localparam int QUEUE_DEPTH  = 4;
  localparam logic [CFG_W-1:0] SIZE_RESET = 9'd256;
  localparam logic [CFG_W-1:0] SIZE_MIN   = 9'd2;

endpackage

>>> rtl/core/brts_front.sv
// Front end: config registers, request intake, coordinate clamp/scale and classification.
`timescale 1ns / 1ps
module brts_front #(
  parameter int MAX_WIDTH     = 256,
  parameter int MAX_HEIGHT    = 256,
  parameter int FRACTION_BITS = 16,
  parameter int CBW           = 8,
  parameter int RBW           = 8,
  parameter int PW            = 34,
  parameter int QW            = 51
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_we_i,
  input  brts_pkg::reg_idx_e               cfg_idx_i,
  input  logic [brts_pkg::CFG_W-1:0]       cfg_data_i,
  input  logic                             in_valid_i,
  output logic                             in_ready_o,
  input  brts_pkg::op_e                    in_op_i,
  input  logic [brts_pkg::IDX_W-1:0]       in_col_i,
  input  logic [brts_pkg::IDX_W-1:0]       in_row_i,
  input  logic [brts_pkg::TEXEL_W-1:0]     in_rgba_i,
  input  logic signed [brts_pkg::COORD_W-1:0] in_u_i,
  input  logic signed [brts_pkg::COORD_W-1:0] in_v_i,
  output logic                             q_valid_o,
  input  logic                             q_ready_i,
  output logic [QW-1:0]                    q_data_o
);
  import brts_pkg::*;

  localparam int FW = FRACTION_BITS + 1;
  localparam int XW = (FRACTION_BITS + 2 > COORD_W) ? FRACTION_BITS + 2 : COORD_W;
  localparam int MW = FW + CFG_W;
  localparam int IW = MW - FRACTION_BITS;
  localparam logic signed [XW-1:0] ONE_X = XW'(1) <<< FRACTION_BITS;
  localparam logic [FW-1:0] ONE_F = FW'(1) << FRACTION_BITS;

  logic [CFG_W-1:0] width_q, height_q;
  logic [CFG_W-1:0] w_use, h_use;

  logic             f_valid_q;
  op_e              f_op_q;
  logic [CBW-1:0]   f_col_q;
  logic [RBW-1:0]   f_row_q;
  logic [TEXEL_W-1:0] f_rgba_q;
  logic [MW-1:0]    f_xu_q, f_xv_q;
  logic [CFG_W-1:0] f_wm1_q, f_hm1_q;

  logic             accept, wr_ok;
  logic [IW-1:0]    iu, iv;
  logic [FW-1:0]    ru, rv;
  logic [PW-1:0]    payload;

  function automatic logic [FW-1:0] clamp_coord(input logic signed [COORD_W-1:0] c);
    logic signed [XW-1:0] cx;
    cx = XW'(c);
    if (cx < 0) return '0;
    else if (cx > ONE_X) return ONE_F;
    else return FW'(cx);
  endfunction

  function automatic logic [CFG_W-1:0] size_use(input logic [CFG_W-1:0] r, input int mx);
    if (r < SIZE_MIN) return SIZE_MIN;
    else if (13'(r) > 13'(mx)) return CFG_W'(mx);
    else return r;
  endfunction

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= SIZE_RESET;
      height_q <= SIZE_RESET;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_WIDTH:  width_q  <= cfg_data_i;
        REG_HEIGHT: height_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  assign w_use = size_use(width_q, MAX_WIDTH);
  assign h_use = size_use(height_q, MAX_HEIGHT);

  assign in_ready_o = !f_valid_q || q_ready_i;
  assign accept     = in_valid_i && in_ready_o;
  // writes outside the store are dropped here
  assign wr_ok      = (13'(in_col_i) < 13'(MAX_WIDTH)) && (13'(in_row_i) < 13'(MAX_HEIGHT));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      f_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      f_valid_q <= accept && (in_op_i == OP_SAMPLE || wr_ok);
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      f_op_q   <= in_op_i;
      f_col_q  <= CBW'(in_col_i);
      f_row_q  <= RBW'(in_row_i);
      f_rgba_q <= in_rgba_i;
      f_xu_q   <= MW'(clamp_coord(in_u_i)) * MW'(w_use - 1'b1);
      f_xv_q   <= MW'(clamp_coord(in_v_i)) * MW'(h_use - 1'b1);
      f_wm1_q  <= w_use - 1'b1;
      f_hm1_q  <= h_use - 1'b1;
    end
  end

  // split into base index and weight; last column/row steps back with full weight
  always_comb begin
    iu = f_xu_q[MW-1:FRACTION_BITS];
    ru = {1'b0, f_xu_q[FRACTION_BITS-1:0]};
    if (iu >= IW'(f_wm1_q)) begin
      iu = IW'(f_wm1_q) - 1'b1;
      ru = ONE_F;
    end
    iv = f_xv_q[MW-1:FRACTION_BITS];
    rv = {1'b0, f_xv_q[FRACTION_BITS-1:0]};
    if (iv >= IW'(f_hm1_q)) begin
      iv = IW'(f_hm1_q) - 1'b1;
      rv = ONE_F;
    end
    if (f_op_q == OP_SAMPLE) begin
      payload  = PW'({rv, ru});
      q_data_o = {f_op_q, CBW'(iu), RBW'(iv), payload};
    end else begin
      payload  = PW'(f_rgba_q);
      q_data_o = {f_op_q, f_col_q, f_row_q, payload};
    end
  end

  assign q_valid_o = f_valid_q;

endmodule

>>> rtl/core/brts_queue.sv
// Small FIFO between the front end and the blend back end.
`timescale 1ns / 1ps
module brts_queue #(
  parameter int W     = 51,
  parameter int DEPTH = 4
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         push_valid_i,
  output logic         push_ready_o,
  input  logic [W-1:0] push_data_i,
  output logic         pop_valid_o,
  input  logic         pop_ready_i,
  output logic [W-1:0] pop_data_o
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [W-1:0]     mem_q [DEPTH];
  logic [PTR_W-1:0] wr_ptr_q, rd_ptr_q;
  logic [CNT_W-1:0] count_q;
  logic             push, pop;

  assign push_ready_o = (count_q != CNT_W'(DEPTH));
  assign pop_valid_o  = (count_q != '0);
  assign push         = push_valid_i && push_ready_o;
  assign pop          = pop_valid_o && pop_ready_i;
  assign pop_data_o   = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (push) mem_q[wr_ptr_q] <= push_data_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push) wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
      if (pop)  rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
      count_q <= count_q + CNT_W'(push) - CNT_W'(pop);
    end
  end

  a_count_up: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push && !pop) |=> count_q == $past(count_q) + 1'b1)
    else $error("queue count did not grow on push");
  a_count_max: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CNT_W'(DEPTH))
    else $error("queue overfilled");

endmodule

>>> rtl/core/brts_back.sv
// Back end: four parity banks of texel storage, bilinear weights, blend and output register.
`timescale 1ns / 1ps
module brts_back #(
  parameter int FRACTION_BITS = 16,
  parameter int CBW           = 8,
  parameter int RBW           = 8,
  parameter int PW            = 34,
  parameter int QW            = 51
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                q_valid_i,
  output logic                                q_ready_o,
  input  logic [QW-1:0]                       q_data_i,
  output logic                                out_valid_o,
  input  logic                                out_ready_i,
  output logic [brts_pkg::OUT_TDATA_W-1:0]    out_data_o
);
  import brts_pkg::*;

  localparam int FW  = FRACTION_BITS + 1;
  localparam int WW  = 2 * FW;
  localparam int PRW = WW + CHAN_W;
  localparam int SW  = PRW + 2;
  localparam int HCW = (CBW > 1) ? CBW - 1 : 1;
  localparam int HRW = (RBW > 1) ? RBW - 1 : 1;
  localparam int AW  = HCW + HRW;
  localparam logic [FW-1:0] ONE_F = FW'(1) << FRACTION_BITS;
  localparam logic [SW-1:0] HALF  = SW'(1) << (2 * FRACTION_BITS - 1);

  logic           e_op_bit;
  op_e            e_op;
  logic [CBW-1:0] e_col;
  logic [RBW-1:0] e_row;
  logic [PW-1:0]  e_pay;
  logic [FW-1:0]  e_r, e_s;
  logic           back_en, pop;

  logic [TEXEL_W-1:0] rd_q [4];
  logic               b1_valid_q, b1_pc_q, b1_pr_q;
  logic [WW-1:0]      w_q [4];
  logic               b2_valid_q;
  logic [PRW-1:0]     prod_q [4][4];
  logic               out_valid_q;
  logic [CHAN_W-1:0]  chan_q [4];
  logic [TEXEL_W-1:0] corner [4];

  assign {e_op_bit, e_col, e_row, e_pay} = q_data_i;
  assign e_op = op_e'(e_op_bit);
  assign e_r = e_pay[FW-1:0];
  assign e_s = e_pay[2*FW-1:FW];

  // whole back end advances unless the output holds a result not yet taken
  assign back_en   = !out_valid_q || out_ready_i;
  assign q_ready_o = back_en;
  assign pop       = q_valid_i && back_en;

  // bank b holds texels whose column parity is b[0] and row parity is b[1]
  for (genvar b = 0; b < 4; b++) begin : g_bank
    localparam logic CP = 1'(b % 2);
    localparam logic RP = 1'(b / 2);
    logic [TEXEL_W-1:0] mem [2**AW];
    logic [CBW-1:0]     col_sel;
    logic [RBW-1:0]     row_sel;
    logic [AW-1:0]      addr;
    logic               we, re;

    assign col_sel = (e_col[0] == CP) ? e_col : CBW'(e_col + 1'b1);
    assign row_sel = (e_row[0] == RP) ? e_row : RBW'(e_row + 1'b1);
    assign addr    = {HRW'(row_sel >> 1), HCW'(col_sel >> 1)};
    assign we      = pop && e_op == OP_WRITE && e_col[0] == CP && e_row[0] == RP;
    assign re      = pop && e_op == OP_SAMPLE;

    always_ff @(posedge clk_i) begin
      if (we) mem[addr] <= e_pay[TEXEL_W-1:0];
      if (re) rd_q[b] <= mem[addr];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      b1_valid_q  <= 1'b0;
      b2_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else if (back_en) begin
      b1_valid_q  <= pop && e_op == OP_SAMPLE;
      b2_valid_q  <= b1_valid_q;
      out_valid_q <= b2_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop && e_op == OP_SAMPLE) begin
      b1_pc_q <= e_col[0];
      b1_pr_q <= e_row[0];
      w_q[0]  <= (ONE_F - e_r) * (ONE_F - e_s);
      w_q[1]  <= e_r * (ONE_F - e_s);
      w_q[2]  <= e_r * e_s;
      w_q[3]  <= (ONE_F - e_r) * e_s;
    end
  end

  function automatic logic [TEXEL_W-1:0] pick(input logic rp, input logic cp,
                                              input logic [TEXEL_W-1:0] t0,
                                              input logic [TEXEL_W-1:0] t1,
                                              input logic [TEXEL_W-1:0] t2,
                                              input logic [TEXEL_W-1:0] t3);
    case ({rp, cp})
      2'b00:   return t0;
      2'b01:   return t1;
      2'b10:   return t2;
      default: return t3;
    endcase
  endfunction

  // corners: top-left, top-right, bottom-right, bottom-left
  always_comb begin
    corner[0] = pick(b1_pr_q, b1_pc_q, rd_q[0], rd_q[1], rd_q[2], rd_q[3]);
    corner[1] = pick(b1_pr_q, !b1_pc_q, rd_q[0], rd_q[1], rd_q[2], rd_q[3]);
    corner[2] = pick(!b1_pr_q, !b1_pc_q, rd_q[0], rd_q[1], rd_q[2], rd_q[3]);
    corner[3] = pick(!b1_pr_q, b1_pc_q, rd_q[0], rd_q[1], rd_q[2], rd_q[3]);
  end

  always_ff @(posedge clk_i) begin
    if (back_en && b1_valid_q) begin
      for (int ch = 0; ch < 4; ch++) begin
        for (int k = 0; k < 4; k++) begin
          prod_q[ch][k] <= w_q[k] * corner[k][CHAN_W*ch +: CHAN_W];
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (back_en && b2_valid_q) begin
      for (int ch = 0; ch < 4; ch++) begin
        chan_q[ch] <= CHAN_W'((SW'(prod_q[ch][0]) + SW'(prod_q[ch][1]) + SW'(prod_q[ch][2])
                              + SW'(prod_q[ch][3]) + HALF) >> (2 * FRACTION_BITS));
      end
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = {chan_q[3], chan_q[2], chan_q[1], chan_q[0]};

  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !back_en |=> $stable(b1_valid_q) && $stable(b2_valid_q))
    else $error("blend pipeline moved while stalled");
  a_flow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (b1_valid_q && back_en) |=> b2_valid_q)
    else $error("sample lost between read and multiply stages");

endmodule

>>> rtl/core/bilinear_rgba_texture_sampler.sv
// Sample path: front-end register, queue, bank-read, multiply and output registers. One
// request per cycle while the queue has room; the four parity banks serve all four texel reads
// at once. A 4-entry queue splits the front end from the back end, so intake continues while
// a result waits. Texel writes produce no result. Reset clears control state and sets both
// size registers to 256; texel storage is not cleared and must be written before use.
`timescale 1ns / 1ps
module bilinear_rgba_texture_sampler #(
  parameter int MAX_WIDTH     = 256,
  parameter int MAX_HEIGHT    = 256,
  parameter int FRACTION_BITS = 16
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               cfg_we_i,
  input  brts_pkg::reg_idx_e                 cfg_idx_i,
  input  logic [brts_pkg::CFG_W-1:0]         cfg_data_i,
  input  logic                               s_axis_tvalid,
  output logic                               s_axis_tready,
  // texel_column[7:0], texel_row[15:8], texel_rgba[47:16], u_coord[65:48], v_coord[83:66]
  input  logic [brts_pkg::IN_TDATA_W-1:0]    s_axis_tdata,
  // op[0]
  input  logic                               s_axis_tuser,
  output logic                               m_axis_tvalid,
  input  logic                               m_axis_tready,
  // red[7:0], green[15:8], blue[23:16], alpha[31:24]
  output logic [brts_pkg::OUT_TDATA_W-1:0]   m_axis_tdata
);
  import brts_pkg::*;

  localparam int CBW = $clog2(MAX_WIDTH);
  localparam int RBW = $clog2(MAX_HEIGHT);
  localparam int PW  = (2 * FRACTION_BITS + 2 > TEXEL_W) ? 2 * FRACTION_BITS + 2 : TEXEL_W;
  localparam int QW  = 1 + CBW + RBW + PW;

  logic          q_in_valid, q_in_ready, q_out_valid, q_out_ready;
  logic [QW-1:0] q_in_data, q_out_data;

  brts_front #(
    .MAX_WIDTH(MAX_WIDTH), .MAX_HEIGHT(MAX_HEIGHT), .FRACTION_BITS(FRACTION_BITS),
    .CBW(CBW), .RBW(RBW), .PW(PW), .QW(QW)
  ) u_front (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_idx_i, .cfg_data_i,
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .in_op_i    (op_e'(s_axis_tuser)),
    .in_col_i   (s_axis_tdata[7:0]),
    .in_row_i   (s_axis_tdata[15:8]),
    .in_rgba_i  (s_axis_tdata[47:16]),
    .in_u_i     ($signed(s_axis_tdata[65:48])),
    .in_v_i     ($signed(s_axis_tdata[83:66])),
    .q_valid_o  (q_in_valid),
    .q_ready_i  (q_in_ready),
    .q_data_o   (q_in_data)
  );

  brts_queue #(.W(QW), .DEPTH(QUEUE_DEPTH)) u_queue (
    .clk_i, .rst_ni,
    .push_valid_i (q_in_valid),
    .push_ready_o (q_in_ready),
    .push_data_i  (q_in_data),
    .pop_valid_o  (q_out_valid),
    .pop_ready_i  (q_out_ready),
    .pop_data_o   (q_out_data)
  );

  brts_back #(
    .FRACTION_BITS(FRACTION_BITS), .CBW(CBW), .RBW(RBW), .PW(PW), .QW(QW)
  ) u_back (
    .clk_i, .rst_ni,
    .q_valid_i   (q_out_valid),
    .q_ready_o   (q_out_ready),
    .q_data_i    (q_out_data),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_data_o  (m_axis_tdata)
  );

endmodule

>>> dv/bilinear_rgba_texture_sampler_tb.sv
// Self-checking testbench for the bilinear RGBA texture sampler.
`timescale 1ns / 1ps
module bilinear_rgba_texture_sampler_tb;
  import brts_pkg::*;

  localparam int LATENCY     = 4;
  localparam int CYCLE_LIMIT = 400000;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_we_i = 1'b0;
  reg_idx_e cfg_idx_i = REG_WIDTH;
  logic [CFG_W-1:0] cfg_data_i = '0;
  logic s_axis_tvalid = 1'b0;
  logic s_axis_tready;
  // texel_column, texel_row, texel_rgba, u_coord, v_coord (lowest first)
  logic [IN_TDATA_W-1:0] s_axis_tdata = '0;
  // op
  logic s_axis_tuser = 1'b0;
  logic m_axis_tvalid;
  logic m_axis_tready = 1'b0;
  // red, green, blue, alpha (lowest first)
  logic [OUT_TDATA_W-1:0] m_axis_tdata;

  bilinear_rgba_texture_sampler dut (.*);

  initial begin
    forever #2 clk_i = ~clk_i;
  end

  // predictor state
  logic [31:0] texels [0:65535];
  bit          written [0:65535];
  logic [8:0]  width_reg = 9'd256;
  logic [8:0]  height_reg = 9'd256;
  logic [31:0] pending_pixels [$];

  int  errors = 0;
  int  n_samples = 0, n_writes = 0, n_pixels = 0;
  longint cycles = 0;
  bit  idle_on = 1'b1;

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("Timeout at %0t", $time);
      $display("Verification failed");
      $finish;
    end
  end

  // output ready with random stall bursts
  initial begin
    int n;
    forever begin
      @(posedge clk_i);
      if (idle_on && $urandom_range(0, 3) == 0) begin
        n = $urandom_range(1, 12);
        m_axis_tready <= 1'b0;
        repeat (n) @(posedge clk_i);
      end
      m_axis_tready <= 1'b1;
    end
  end

  // result checker
  always @(posedge clk_i) begin
    logic [31:0] exp_px;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      n_pixels++;
      if (pending_pixels.size() == 0) begin
        $display("%0t: unexpected pixel %h", $time, m_axis_tdata);
        errors++;
      end else begin
        exp_px = pending_pixels.pop_front();
        for (int c = 0; c < 4; c++)
          if (exp_px[8*c +: 8] !== m_axis_tdata[8*c +: 8]) begin
            $display("%0t: channel %0d expected %h actual %h", $time, c,
                     exp_px[8*c +: 8], m_axis_tdata[8*c +: 8]);
            errors++;
          end
      end
    end
  end

  function automatic int clamp_size(logic [8:0] r);
    if (r < 2) return 2;
    if (r > 256) return 256;
    return int'(r);
  endfunction

  function automatic void split_coord(logic [17:0] raw, int n, output int base,
                                      output longint frac);
    longint c, x;
    c = longint'($signed(raw));
    if (c < 0) c = 0;
    if (c > 65536) c = 65536;
    x = c * (n - 1);
    base = int'(x >> 16);
    frac = x & 16'hFFFF;
    if (base >= n - 1) begin
      base = n - 2;
      frac = 65536;
    end
  endfunction

  function automatic logic [31:0] blend_pixel(logic [17:0] u, logic [17:0] v);
    int i0, j0;
    longint r, s, acc;
    longint wt [4];
    logic [31:0] t [4];
    logic [31:0] px;
    split_coord(u, clamp_size(width_reg), i0, r);
    split_coord(v, clamp_size(height_reg), j0, s);
    t[0] = texels[j0*256 + i0];
    t[1] = texels[j0*256 + i0 + 1];
    t[2] = texels[(j0+1)*256 + i0 + 1];
    t[3] = texels[(j0+1)*256 + i0];
    wt[0] = (65536 - r) * (65536 - s);
    wt[1] = r * (65536 - s);
    wt[2] = r * s;
    wt[3] = (65536 - r) * s;
    for (int c = 0; c < 4; c++) begin
      acc = 0;
      for (int k = 0; k < 4; k++) acc += wt[k] * longint'(t[k][8*c +: 8]);
      acc = (acc + (longint'(1) << 31)) >> 32;
      if (acc > 255) acc = 255;
      px[8*c +: 8] = acc[7:0];
    end
    return px;
  endfunction

  function automatic bit sample_safe(logic [17:0] u, logic [17:0] v);
    int i0, j0;
    longint r, s;
    split_coord(u, clamp_size(width_reg), i0, r);
    split_coord(v, clamp_size(height_reg), j0, s);
    return written[j0*256+i0] && written[j0*256+i0+1] &&
           written[(j0+1)*256+i0] && written[(j0+1)*256+i0+1];
  endfunction

  task automatic send_request(op_e op, logic [7:0] col, logic [7:0] row,
                              logic [31:0] rgba, logic [17:0] u, logic [17:0] v);
    int n;
    if (idle_on && $urandom_range(0, 4) == 0) begin
      n = $urandom_range(1, 12);
      s_axis_tvalid <= 1'b0;
      repeat (n) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= op;
    s_axis_tdata  <= {4'b0, v, u, rgba, row, col};
    do @(posedge clk_i); while (!s_axis_tready);
    if (op == OP_WRITE) begin
      texels[{row, col}] = rgba;
      written[{row, col}] = 1'b1;
      n_writes++;
    end else begin
      pending_pixels.push_back(blend_pixel(u, v));
      n_samples++;
    end
  endtask

  task automatic drain_and_pause();
    s_axis_tvalid <= 1'b0;
    while (pending_pixels.size() != 0) @(posedge clk_i);
    repeat (LATENCY + 4) @(posedge clk_i);
  endtask

  task automatic set_size(reg_idx_e idx, logic [8:0] val);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= val;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    if (idx == REG_WIDTH) width_reg = val;
    else height_reg = val;
  endtask

  task automatic write_texel(int col, int row);
    send_request(OP_WRITE, col[7:0], row[7:0], $urandom(), 18'($urandom()),
                 18'($urandom()));
  endtask

  // fill a region of the store with random texels
  task automatic fill_region(int w, int h);
    for (int r = 0; r < h; r++)
      for (int c = 0; c < w; c++) write_texel(c, r);
  endtask

  function automatic logic [17:0] rand_coord();
    case ($urandom_range(0, 5))
      0: return 18'h20000;                         // most negative
      1: return 18'h1FFFF;                         // most positive
      2: return 18'd65536;                         // exactly one
      3: return 18'($urandom_range(0, 65535));
      4: return 18'($urandom_range(65536, 131071)); // one and above; above one clamps
      default: return 18'($urandom());
    endcase
  endfunction

  task automatic random_samples(int count);
    logic [17:0] u, v;
    int k;
    k = 0;
    while (k < count) begin
      u = rand_coord();
      v = rand_coord();
      if (sample_safe(u, v)) begin
        send_request(OP_SAMPLE, 8'($urandom()), 8'($urandom()), $urandom(), u, v);
        k++;
      end
    end
  endtask

  // extremes of the fields, edge handling, clamping, and a full-range texel store write
  task automatic test_directed();
    set_size(REG_WIDTH, 9'd2);
    set_size(REG_HEIGHT, 9'd2);
    send_request(OP_WRITE, 8'd0, 8'd0, 32'h0000_0000, '0, '0);
    send_request(OP_WRITE, 8'd1, 8'd0, 32'hFFFF_FFFF, '1, '1);
    send_request(OP_WRITE, 8'd1, 8'd1, 32'h80FF_0001, '0, '0);
    send_request(OP_WRITE, 8'd0, 8'd1, 32'h7F00_FF10, '0, '0);
    send_request(OP_WRITE, 8'd255, 8'd255, 32'hA5A5_5A5A, '1, '1);
    send_request(OP_SAMPLE, 8'd0, 8'd0, '0, 18'd0, 18'd0);
    send_request(OP_SAMPLE, '1, '1, '1, 18'd65536, 18'd65536);
    send_request(OP_SAMPLE, 8'd0, 8'd0, '0, 18'h20000, 18'h1FFFF);
    send_request(OP_SAMPLE, 8'd0, 8'd0, '0, 18'd32768, 18'd32768);
    send_request(OP_SAMPLE, 8'd0, 8'd0, '0, 18'd1, 18'd65535);
    send_request(OP_SAMPLE, 8'd0, 8'd0, '0, 18'h3FFFF, 18'd65537);
    drain_and_pause();
    // out-of-range size registers clamp to 2
    set_size(REG_WIDTH, 9'd0);
    set_size(REG_HEIGHT, 9'd1);
    send_request(OP_SAMPLE, 8'd0, 8'd0, '0, 18'd40000, 18'd20000);
    send_request(OP_SAMPLE, 8'd0, 8'd0, '0, 18'd65536, 18'd0);
    drain_and_pause();
  endtask

  task automatic test_small_texture();
    set_size(REG_WIDTH, 9'd5);
    set_size(REG_HEIGHT, 9'd3);
    fill_region(5, 3);
    random_samples(40);
    drain_and_pause();
  endtask

  task automatic test_mixed_updates();
    int w, h;
    w = 9; h = 7;
    set_size(REG_WIDTH, 9'(w));
    set_size(REG_HEIGHT, 9'(h));
    fill_region(w, h);
    for (int k = 0; k < 200; k++) begin
      if ($urandom_range(0, 3) == 0) write_texel($urandom_range(0, 255),
                                                 $urandom_range(0, 255));
      else random_samples(1);
    end
    drain_and_pause();
  endtask

  // full-size texture: only the four 2x2 corner blocks of texels are needed at the extremes
  task automatic test_large_sizes();
    set_size(REG_WIDTH, 9'd256);
    set_size(REG_HEIGHT, 9'd511);
    for (int r = 0; r < 256; r += 255)
      for (int c = 0; c < 256; c += 254) begin
        write_texel(c, r); write_texel(c + 1, r);
        write_texel(c, r == 0 ? 1 : 254); write_texel(c + 1, r == 0 ? 1 : 254);
      end
    for (int k = 0; k < 8; k++)
      send_request(OP_SAMPLE, '0, '0, '0, $urandom_range(0, 1) ? 18'h20000 : 18'd65536,
                   $urandom_range(0, 1) ? 18'h1FFFF : 18'h3FFFF);
    drain_and_pause();
  endtask

  task automatic test_back_to_back();
    set_size(REG_WIDTH, 9'd4);
    set_size(REG_HEIGHT, 9'd4);
    fill_region(4, 4);
    idle_on = 1'b0;
    random_samples(80);
    drain_and_pause();
  endtask

  initial begin
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed();
    test_small_texture();
    test_mixed_updates();
    test_large_sizes();
    test_back_to_back();
    $display("Covered %0d texel writes and %0d samples; %0d pixels checked.",
             n_writes, n_samples, n_pixels);
    $display("Sizes swept from clamped minimum to full store, coordinates to both clamps.");
    if (errors == 0 && pending_pixels.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

>>> filelist.f
rtl/core/brts_pkg.sv
rtl/core/brts_front.sv
rtl/core/brts_queue.sv
rtl/core/brts_back.sv
rtl/core/bilinear_rgba_texture_sampler.sv
dv/bilinear_rgba_texture_sampler_tb.sv
